@@ hw/rtl/r2fft_pkg.sv @@
// r2fft_pkg: shared constants, types and twiddle table for the radix-2 FFT.
// No dependencies.
package r2fft_pkg;
	localparam int POINTS_DEF = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int GROWTH = 7;
	localparam int TW_FRAC = 15;
	localparam int ROM_DEPTH = 32;
	localparam int BIN_WIDTH = 6;
	localparam int ADDR_W = 1;

	localparam logic [0:0] REG_INVERSE = 1'b0;

	typedef logic signed [16:0] tw_t;

	// cos(2*pi*k/64) in Q1.15, k = 0..16
	function automatic tw_t quarter_cos(input logic [4:0] k);
		tw_t v;
		unique case (k)
			5'd0:  v = 17'sd32767;
			5'd1:  v = 17'sd32610;
			5'd2:  v = 17'sd32138;
			5'd3:  v = 17'sd31357;
			5'd4:  v = 17'sd30274;
			5'd5:  v = 17'sd28899;
			5'd6:  v = 17'sd27246;
			5'd7:  v = 17'sd25330;
			5'd8:  v = 17'sd23170;
			5'd9:  v = 17'sd20788;
			5'd10: v = 17'sd18205;
			5'd11: v = 17'sd15447;
			5'd12: v = 17'sd12540;
			5'd13: v = 17'sd9512;
			5'd14: v = 17'sd6393;
			5'd15: v = 17'sd3212;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

	function automatic tw_t tw_cos(input logic [4:0] k);
		if (k <= 5'd16)
			return quarter_cos(k);
		return -quarter_cos(5'(6'd32 - {1'b0, k}));
	endfunction

	function automatic tw_t tw_sin(input logic [4:0] k);
		if (k <= 5'd16)
			return quarter_cos(5'(5'd16 - k));
		return quarter_cos(5'(k - 5'd16));
	endfunction
endpackage

@@ hw/rtl/radix2_complex_fft.sv @@
// radix2_complex_fft: in-place radix-2 DIT FFT over one pair of RAMs with a single butterfly.
// Depends on r2fft_pkg.
//
// Usage: samples enter on sample_re/sample_im with valid/ready in time order. After
// POINTS samples the block computes the transform and returns POINTS results in bin order
// on result_re/result_im/bin_index with last_result on the final one, under valid/ready.
// inverse_mode (APB, byte address 0) selects the inverse transform, scaled by 1/POINTS;
// its value at the last sample of a frame applies.
// Loading accepts one sample per cycle. The compute phase runs one butterfly at a time,
// stepping through read p, read q, multiply, add and write p, write q; p and q are read
// in turn through the single read port of the store. Output then takes one RAM read
// per result.
// While computing or emitting, in ready is low. A stalled receiver holds the output
// register and the sequencer waits. Reset clears the sequencer, load count and
// inverse_mode; store contents are undefined until loaded.
module radix2_complex_fft #(
	parameter int POINTS = r2fft_pkg::POINTS_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [r2fft_pkg::ADDR_W+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] result_re,
	output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] result_im,
	output logic [r2fft_pkg::BIN_WIDTH-1:0] bin_index,
	output logic last_result
);
	import r2fft_pkg::*;

	localparam int LOG = $clog2(POINTS);
	localparam int AW = LOG;
	localparam int WW = SAMPLE_WIDTH + GROWTH;
	localparam int PW = WW + 18;
	localparam int SW = $clog2(LOG + 1);
	localparam int HW = (AW > 1) ? AW - 1 : 1;
	localparam logic [4:0] STEP_BASE = 5'(64 / POINTS);

	typedef enum logic [3:0] {
		S_LOAD, S_RDP, S_RDQ, S_MUL, S_ADD, S_WR, S_ORD, S_OWAIT, S_OPUT
	} state_t;

	state_t state_q;
	logic [AW-1:0] load_cnt_q;
	logic inv_q, inv_frame_q;
	logic [SW-1:0] stage_q;
	logic [HW-1:0] bfly_q;
	logic [AW-1:0] out_idx_q;

	logic signed [WW-1:0] mem_re [POINTS];
	logic signed [WW-1:0] mem_im [POINTS];
	logic signed [WW-1:0] rd_re_q, rd_im_q;
	logic signed [WW-1:0] p_re_q, p_im_q;
	logic signed [PW-1:0] m_ac_q, m_bs_q, m_bc_q, m_as_q;
	logic signed [WW-1:0] o_q_a_q, o_q_b_q;

	logic [AW-1:0] rd_addr, wr_addr, addr_p, addr_q, brev;
	logic [AW-1:0] half, low_mask;
	logic [4:0] tw_k;
	logic wr_en;
	logic signed [WW-1:0] wr_re, wr_im;
	logic apb_wr;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = {31'd0, inv_q};

	always_comb begin
		for (int i = 0; i < AW; i++)
			brev[i] = load_cnt_q[AW-1-i];
	end

	// butterfly addressing: p = insert a zero at bit 'stage' of the butterfly count
	always_comb begin
		logic [AW:0] ext;
		half = AW'(1) << stage_q;
		low_mask = half - AW'(1);
		ext = {1'b0, AW'(bfly_q)};
		addr_p = AW'(((ext & ~{1'b0, low_mask}) << 1) | (ext & {1'b0, low_mask}));
		addr_q = addr_p | half;
		tw_k = 5'((32'(addr_p & low_mask) * 32'(STEP_BASE)) << (LOG - 1 - 32'(stage_q)));
	end

	// a is the real role, b the imaginary role; swapped for inverse.
	// q is taken straight from the read register, which holds it in S_MUL.
	logic signed [WW-1:0] pa, pb, qa, qb;
	assign pa = inv_frame_q ? p_im_q : p_re_q;
	assign pb = inv_frame_q ? p_re_q : p_im_q;
	assign qa = inv_frame_q ? rd_im_q : rd_re_q;
	assign qb = inv_frame_q ? rd_re_q : rd_im_q;

	function automatic logic signed [WW-1:0] sat(input logic signed [WW+1:0] v);
		logic signed [WW+1:0] hi, lo;
		hi = (WW+2)'((1 <<< (WW-1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[WW-1:0];
		if (v < lo) return lo[WW-1:0];
		return v[WW-1:0];
	endfunction

	logic signed [PW:0] tr_full, ti_full;
	logic signed [WW+1:0] tr, ti;
	always_comb begin
		tr_full = (PW+1)'(m_ac_q) + (PW+1)'(m_bs_q) + (PW+1)'(1 <<< (TW_FRAC-1));
		ti_full = (PW+1)'(m_bc_q) - (PW+1)'(m_as_q) + (PW+1)'(1 <<< (TW_FRAC-1));
		tr = (WW+2)'(tr_full >>> TW_FRAC);
		ti = (WW+2)'(ti_full >>> TW_FRAC);
	end

	logic signed [WW-1:0] sum_p_a, sum_p_b;
	assign sum_p_a = sat((WW+2)'(pa) + tr);
	assign sum_p_b = sat((WW+2)'(pb) + ti);

	// RAM ports
	always_comb begin
		rd_addr = addr_p;
		wr_en = 1'b0;
		wr_addr = brev;
		wr_re = WW'(sample_re);
		wr_im = WW'(sample_im);
		unique case (state_q)
			S_RDQ: rd_addr = addr_q;
			S_ORD, S_OWAIT: rd_addr = out_idx_q;
			S_LOAD: wr_en = sample_valid;
			S_ADD: begin
				wr_en = 1'b1;
				wr_addr = addr_p;
				wr_re = inv_frame_q ? sum_p_b : sum_p_a;
				wr_im = inv_frame_q ? sum_p_a : sum_p_b;
			end
			S_WR: begin
				wr_en = 1'b1;
				wr_addr = addr_q;
				wr_re = inv_frame_q ? o_q_b_q : o_q_a_q;
				wr_im = inv_frame_q ? o_q_a_q : o_q_b_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_re[wr_addr] <= wr_re;
			mem_im[wr_addr] <= wr_im;
		end
		rd_re_q <= mem_re[rd_addr];
		rd_im_q <= mem_im[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_RDQ: begin
				p_re_q <= rd_re_q;
				p_im_q <= rd_im_q;
			end
			S_MUL: begin
				m_ac_q <= PW'(qa * tw_cos(tw_k));
				m_bs_q <= PW'(qb * tw_sin(tw_k));
				m_bc_q <= PW'(qb * tw_cos(tw_k));
				m_as_q <= PW'(qa * tw_sin(tw_k));
			end
			S_ADD: begin
				o_q_a_q <= sat((WW+2)'(pa) - tr);
				o_q_b_q <= sat((WW+2)'(pb) - ti);
			end
			default: ;
		endcase
	end

	logic signed [WW-1:0] res_re_c, res_im_c;
	always_comb begin
		logic signed [WW:0] r, i;
		r = (WW+1)'(rd_re_q) + (WW+1)'((1 <<< LOG) >>> 1);
		i = (WW+1)'(rd_im_q) + (WW+1)'((1 <<< LOG) >>> 1);
		res_re_c = inv_frame_q ? WW'(r >>> LOG) : rd_re_q;
		res_im_c = inv_frame_q ? WW'(i >>> LOG) : rd_im_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			load_cnt_q <= '0;
			inv_q <= 1'b0;
			inv_frame_q <= 1'b0;
			stage_q <= '0;
			bfly_q <= '0;
			out_idx_q <= '0;
			result_valid <= 1'b0;
			result_re <= '0;
			result_im <= '0;
			bin_index <= '0;
			last_result <= 1'b0;
		end else begin
			if (apb_wr && paddr[ADDR_W+1:2] == REG_INVERSE)
				inv_q <= pwdata[0];
			if (state_q == S_OWAIT && (!result_valid || result_ready))
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
			unique case (state_q)
				S_LOAD: if (sample_valid) begin
					load_cnt_q <= load_cnt_q + 1'b1;
					if (load_cnt_q == AW'(POINTS - 1)) begin
						inv_frame_q <= inv_q;
						stage_q <= '0;
						bfly_q <= '0;
						state_q <= S_RDP;
					end
				end
				S_RDP: state_q <= S_RDQ;
				S_RDQ: state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= S_WR;
				S_WR: begin
					if (bfly_q == HW'(POINTS/2 - 1)) begin
						bfly_q <= '0;
						if (stage_q == SW'(LOG - 1)) begin
							out_idx_q <= '0;
							state_q <= S_ORD;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= S_RDP;
						end
					end else begin
						bfly_q <= bfly_q + 1'b1;
						state_q <= S_RDP;
					end
				end
				S_ORD: state_q <= S_OWAIT;
				S_OWAIT: if (!result_valid || result_ready) begin
					result_re <= res_re_c;
					result_im <= res_im_c;
					bin_index <= BIN_WIDTH'(out_idx_q);
					last_result <= (out_idx_q == AW'(POINTS - 1));
					state_q <= S_OPUT;
				end
				S_OPUT: begin
					out_idx_q <= out_idx_q + 1'b1;
					state_q <= (out_idx_q == AW'(POINTS - 1)) ? S_LOAD : S_ORD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign sample_ready = (state_q == S_LOAD);

	a_busy_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !sample_ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid && $stable(bin_index))
		else $error("result dropped");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |-> (bin_index == BIN_WIDTH'(POINTS - 1)))
		else $error("last flag misplaced");
endmodule
